### rtl/pd_pkg.sv
// Shared operation codes, status codes and command types for the positional deque.
`timescale 1ns / 1ps
package pd_pkg;

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_INSERT     = 3'd4;
  localparam logic [2:0] OP_ERASE      = 3'd5;
  localparam logic [2:0] OP_CLEAR      = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] status;
  } cmd_ctl_t;

endpackage

### rtl/positional_deque.sv
// Top level of the positional deque: front end, command queue and back end.
`timescale 1ns / 1ps
// A bounded ordered sequence of up to CAPACITY data words, held as a circular
// buffer in one single-port-read RAM. Requests push or pop at either end,
// insert or erase at a position, or clear; each returns one response beat with
// status, new count, and the front and back values. The front end takes a
// request beat in any cycle the two-entry command queue has room, so requests
// are accepted while earlier ones are still being carried out; an accepted
// request is registered in the command queue and passed on from there. The
// back end handles one request at a time: after any moves it reads the front
// value and then the back value, or gives zeros for both when the sequence is
// left empty. An insert or erase that leaves entries stored moves the entries
// behind the position, each with one read and one write, since the RAM has one
// read port with a registered output. While an earlier response beat waits to
// be taken, the back end holds in its done state.
module positional_deque import pd_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [2:0]                     operation,
  input  logic [DATA_WIDTH-1:0]          value,
  input  logic [$clog2(CAPACITY+1)-1:0]  position,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [1:0]                     status,
  output logic [$clog2(CAPACITY+1)-1:0]  count,
  output logic [DATA_WIDTH-1:0]          front_value,
  output logic [DATA_WIDTH-1:0]          back_value,
  output logic                           not_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CTL_W = $bits(cmd_ctl_t);
  localparam int Q_W   = CTL_W + DATA_WIDTH + 2 * CNT_W;

  logic                  f_valid;
  logic                  f_ready;
  cmd_ctl_t              f_ctl;
  logic [DATA_WIDTH-1:0] f_value;
  logic [CNT_W-1:0]      f_position;
  logic [CNT_W-1:0]      f_count;
  logic [Q_W-1:0]        f_data;

  logic                  b_valid;
  logic                  b_ready;
  logic [Q_W-1:0]        b_data;
  cmd_ctl_t              b_ctl;
  logic [DATA_WIDTH-1:0] b_value;
  logic [CNT_W-1:0]      b_position;
  logic [CNT_W-1:0]      b_count;

  pd_front #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .operation    (operation),
    .value        (value),
    .position     (position),
    .cmd_valid    (f_valid),
    .cmd_ready    (f_ready),
    .cmd_ctl      (f_ctl),
    .cmd_value    (f_value),
    .cmd_position (f_position),
    .cmd_count    (f_count)
  );

  assign f_data = {f_ctl, f_value, f_position, f_count};

  pd_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  assign {b_ctl, b_value, b_position, b_count} = b_data;

  pd_back #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (b_valid),
    .cmd_ready    (b_ready),
    .cmd_ctl      (b_ctl),
    .cmd_value    (b_value),
    .cmd_position (b_position),
    .cmd_count    (b_count),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .status       (status),
    .count        (count),
    .front_value  (front_value),
    .back_value   (back_value),
    .not_empty    (not_empty)
  );

endmodule

### rtl/pd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module pd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/pd_front.sv
// Front end: accepts requests, tracks the count and works out status and new count.
`timescale 1ns / 1ps
module pd_front import pd_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [2:0]                     operation,
  input  logic [DATA_WIDTH-1:0]          value,
  input  logic [$clog2(CAPACITY+1)-1:0]  position,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output cmd_ctl_t                       cmd_ctl,
  output logic [DATA_WIDTH-1:0]          cmd_value,
  output logic [$clog2(CAPACITY+1)-1:0]  cmd_position,
  output logic [$clog2(CAPACITY+1)-1:0]  cmd_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] fcount;
  logic [CNT_W-1:0] fcount_next;
  logic [1:0]       status;
  logic             full;
  logic             empty;

  assign full  = (fcount == CNT_W'(CAPACITY));
  assign empty = (fcount == '0);

  always_comb begin
    status      = ST_OK;
    fcount_next = fcount;
    unique case (operation)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          fcount_next = fcount + 1'b1;
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          fcount_next = fcount - 1'b1;
        end
      end
      OP_INSERT: begin
        // The position check takes precedence over the full check.
        if (position > fcount) begin
          status = ST_BADPOS;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          fcount_next = fcount + 1'b1;
        end
      end
      OP_ERASE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (position >= fcount) begin
          status = ST_BADPOS;
        end else begin
          fcount_next = fcount - 1'b1;
        end
      end
      OP_CLEAR: begin
        fcount_next = '0;
      end
      default: begin
        fcount_next = fcount;
      end
    endcase
  end

  assign req_ready      = cmd_ready;
  assign cmd_valid      = req_valid;
  assign cmd_ctl.op     = operation;
  assign cmd_ctl.status = status;
  assign cmd_value      = value;
  assign cmd_position   = position;
  assign cmd_count      = fcount_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount <= '0;
    end else if (req_valid && req_ready) begin
      fcount <= fcount_next;
    end
  end

endmodule

### rtl/pd_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module pd_queue import pd_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0]  slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### rtl/pd_back.sv
// Back end: carries out commands on a circular buffer in RAM and forms each response.
`timescale 1ns / 1ps
module pd_back import pd_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  cmd_ctl_t                       cmd_ctl,
  input  logic [DATA_WIDTH-1:0]          cmd_value,
  input  logic [$clog2(CAPACITY+1)-1:0]  cmd_position,
  input  logic [$clog2(CAPACITY+1)-1:0]  cmd_count,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [1:0]                     status,
  output logic [$clog2(CAPACITY+1)-1:0]  count,
  output logic [DATA_WIDTH-1:0]          front_value,
  output logic [DATA_WIDTH-1:0]          back_value,
  output logic                           not_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MOVE_RD  = 3'd1;
  localparam logic [2:0] S_MOVE_WR  = 3'd2;
  localparam logic [2:0] S_RD_FRONT = 3'd3;
  localparam logic [2:0] S_RD_BACK  = 3'd4;
  localparam logic [2:0] S_CAP_BACK = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]            state;
  logic [AW-1:0]         head;
  logic [CNT_W-1:0]      bcount;
  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      limit;
  logic                  up;
  logic [DATA_WIDTH-1:0] value_r;
  logic [1:0]            status_r;
  logic [DATA_WIDTH-1:0] front_r;
  logic [DATA_WIDTH-1:0] back_r;

  logic                  we;
  logic [CNT_W-1:0]      wr_log;
  logic [CNT_W-1:0]      rd_log;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic                  cmd_ok;
  logic                  take;

  // Maps a logical index to a RAM address relative to the head, wrapping once.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CNT_W-1:0] offs);
    logic [SUM_W-1:0] sum;
    begin
      sum = SUM_W'(base) + SUM_W'(offs);
      if (sum >= SUM_W'(CAPACITY)) begin
        sum = sum - SUM_W'(CAPACITY);
      end
      return sum[AW-1:0];
    end
  endfunction

  assign cmd_ready = (state == S_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign cmd_ok    = (cmd_ctl.status == ST_OK);
  assign wr_addr   = phys(head, wr_log);
  assign rd_addr   = phys(head, rd_log);

  always_comb begin
    we      = 1'b0;
    wr_log  = idx;
    wr_data = rd_data;
    rd_log  = idx;
    unique case (state)
      S_IDLE: begin
        if (take && cmd_ok && cmd_ctl.op == OP_PUSH_BACK) begin
          we      = 1'b1;
          wr_log  = bcount;
          wr_data = cmd_value;
        end else if (take && cmd_ok && cmd_ctl.op == OP_PUSH_FRONT) begin
          // One below the head, modulo the capacity.
          we      = 1'b1;
          wr_log  = CNT_W'(CAPACITY - 1);
          wr_data = cmd_value;
        end
      end
      S_MOVE_RD: begin
        if (idx == limit) begin
          we      = up;
          wr_data = value_r;
        end else begin
          rd_log = up ? idx - 1'b1 : idx + 1'b1;
        end
      end
      S_MOVE_WR: begin
        we = 1'b1;
      end
      S_RD_FRONT: begin
        rd_log = '0;
      end
      S_RD_BACK: begin
        rd_log = bcount - 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  pd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      bcount    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            bcount <= cmd_count;
            if (cmd_ok && cmd_ctl.op == OP_PUSH_FRONT) begin
              head <= (head == '0) ? AW'(CAPACITY - 1) : head - 1'b1;
            end else if (cmd_ok && cmd_ctl.op == OP_POP_FRONT) begin
              head <= (head == AW'(CAPACITY - 1)) ? '0 : head + 1'b1;
            end
            if (cmd_ok && (cmd_ctl.op == OP_INSERT || cmd_ctl.op == OP_ERASE)) begin
              state <= S_MOVE_RD;
            end else begin
              state <= S_RD_FRONT;
            end
          end
        end
        S_MOVE_RD: begin
          state <= (idx == limit) ? S_RD_FRONT : S_MOVE_WR;
        end
        S_MOVE_WR: begin
          state <= S_MOVE_RD;
        end
        S_RD_FRONT: begin
          state <= (bcount == '0) ? S_DONE : S_RD_BACK;
        end
        S_RD_BACK: begin
          state <= S_CAP_BACK;
        end
        S_CAP_BACK: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      value_r  <= cmd_value;
      status_r <= cmd_ctl.status;
      up       <= (cmd_ctl.op == OP_INSERT);
      // Insert walks down from the old end to the position; erase walks up
      // from the position to the old last entry.
      if (cmd_ctl.op == OP_INSERT) begin
        idx   <= bcount;
        limit <= cmd_position;
      end else begin
        idx   <= cmd_position;
        limit <= bcount - 1'b1;
      end
    end
    if (state == S_MOVE_WR) begin
      idx <= up ? idx - 1'b1 : idx + 1'b1;
    end
    if (state == S_RD_FRONT && bcount == '0) begin
      front_r <= '0;
      back_r  <= '0;
    end
    if (state == S_RD_BACK) begin
      front_r <= rd_data;
    end
    if (state == S_CAP_BACK) begin
      back_r <= rd_data;
    end
    if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
      status      <= status_r;
      count       <= bcount;
      front_value <= front_r;
      back_value  <= back_r;
      not_empty   <= (bcount != '0);
    end
  end

endmodule

### rtl/pd_checker.sv
// Port-level checks on the positional deque, bound to the top level.
`timescale 1ns / 1ps
module pd_checker import pd_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [1:0]                     status,
  input logic [$clog2(CAPACITY+1)-1:0]  count,
  input logic [DATA_WIDTH-1:0]          front_value,
  input logic [DATA_WIDTH-1:0]          back_value,
  input logic                           not_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_not_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (not_empty == (count != '0)))
    else $error("not_empty disagrees with count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !not_empty) |-> (front_value == '0 && back_value == '0))
    else $error("values not zero on an empty sequence");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FULL) |-> count == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(count)))
    else $error("stalled response beat changed");

endmodule

bind positional_deque pd_checker #(
  .CAPACITY   (CAPACITY),
  .DATA_WIDTH (DATA_WIDTH)
) u_pd_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp_valid),
  .rsp_ready   (rsp_ready),
  .status      (status),
  .count       (count),
  .front_value (front_value),
  .back_value  (back_value),
  .not_empty   (not_empty)
);

### dv/positional_deque_tb.sv
// Self-checking testbench for the positional deque: directed and random requests against a queue-based predictor.
`timescale 1ns / 1ps
module positional_deque_tb import pd_pkg::*;;

  localparam int CAP = 64;
  localparam int DW  = 32;
  localparam int PW  = $clog2(CAP + 1);

  typedef struct packed {
    logic [2:0]    op;
    logic [DW-1:0] value;
    logic [PW-1:0] position;
  } request_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [PW-1:0] count;
    logic [DW-1:0] front;
    logic [DW-1:0] back;
    logic          not_empty;
  } reply_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_HOVER, PH_NOISE} phase_kind_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  logic [2:0]    operation = OP_CLEAR;
  logic [DW-1:0] value = '0;
  logic [PW-1:0] position = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  logic [1:0]    status;
  logic [PW-1:0] count;
  logic [DW-1:0] front_value;
  logic [DW-1:0] back_value;
  logic          not_empty;

  request_t      pending[$];
  reply_t        expected_replies[$];
  logic [DW-1:0] contents[$];

  request_t in_flight;
  reply_t   want;
  int       plan_level = 0;
  int       planned = 0;
  int       accepted = 0;
  int       checked = 0;
  int       errors = 0;
  int       peak_level = 0;
  int       status_seen[4] = '{0, 0, 0, 0};
  int       send_wait = 0;
  int       take_wait = 0;
  bit       send_calm = 1'b0;
  bit       take_calm = 1'b0;

  always #1 clk = ~clk;

  positional_deque u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .operation   (operation),
    .value       (value),
    .position    (position),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .count       (count),
    .front_value (front_value),
    .back_value  (back_value),
    .not_empty   (not_empty)
  );

  // Applies one request to the shadow sequence and returns the reply it should give.
  function automatic reply_t apply_request(request_t r);
    reply_t rep;
    int     level;
    level = contents.size();
    rep = '0;
    rep.status = ST_OK;
    case (r.op)
      OP_PUSH_BACK: begin
        if (level >= CAP) rep.status = ST_FULL;
        else contents.insert(level, r.value);
      end
      OP_PUSH_FRONT: begin
        if (level >= CAP) rep.status = ST_FULL;
        else contents.insert(0, r.value);
      end
      OP_POP_BACK: begin
        if (level == 0) rep.status = ST_EMPTY;
        else contents.delete(level - 1);
      end
      OP_POP_FRONT: begin
        if (level == 0) rep.status = ST_EMPTY;
        else contents.delete(0);
      end
      OP_INSERT: begin
        // The position check takes precedence over the full check.
        if (r.position > level) rep.status = ST_BADPOS;
        else if (level >= CAP) rep.status = ST_FULL;
        else contents.insert(int'(r.position), r.value);
      end
      OP_ERASE: begin
        if (level == 0) rep.status = ST_EMPTY;
        else if (r.position >= level) rep.status = ST_BADPOS;
        else contents.delete(int'(r.position));
      end
      OP_CLEAR: contents.delete();
      default: ;
    endcase
    rep.count = PW'(contents.size());
    rep.not_empty = (contents.size() != 0);
    if (rep.not_empty) begin
      rep.front = contents[0];
      rep.back  = contents[$];
    end
    return rep;
  endfunction

  // Queues a request and tracks the occupancy it should leave, so that later
  // positions can be aimed at the live part of the sequence.
  task automatic add_request(input logic [2:0] op, input logic [DW-1:0] val,
                             input logic [PW-1:0] pos);
    request_t r;
    r.op = op;
    r.value = val;
    r.position = pos;
    pending.insert(pending.size(), r);
    planned++;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: if (plan_level < CAP) plan_level++;
      OP_POP_BACK, OP_POP_FRONT:   if (plan_level > 0) plan_level--;
      OP_INSERT: if (pos <= plan_level && plan_level < CAP) plan_level++;
      OP_ERASE:  if (plan_level > 0 && pos < plan_level) plan_level--;
      OP_CLEAR:  plan_level = 0;
      default: ;
    endcase
  endtask

  task automatic random_request(input phase_kind_t kind);
    int            grow_pct;
    int            pick;
    logic [2:0]    op;
    logic [PW-1:0] pos;
    logic [DW-1:0] val;
    case (kind)
      PH_FILL:  grow_pct = 88;
      PH_DRAIN: grow_pct = 12;
      default:  grow_pct = 50;
    endcase
    pick = $urandom_range(0, 9);
    val = (pick == 0) ? '0 : (pick == 1) ? '1 : DW'($urandom);
    pos = PW'($urandom_range(0, CAP));
    if (kind == PH_NOISE) begin
      op = 3'($urandom_range(0, 6));
    end else if (kind == PH_HOVER && $urandom_range(0, 99) == 0) begin
      op = OP_CLEAR;
    end else if ($urandom_range(0, 99) < grow_pct) begin
      pick = $urandom_range(0, 2);
      op = (pick == 0) ? OP_PUSH_BACK : (pick == 1) ? OP_PUSH_FRONT : OP_INSERT;
    end else begin
      pick = $urandom_range(0, 2);
      op = (pick == 0) ? OP_POP_BACK : (pick == 1) ? OP_POP_FRONT : OP_ERASE;
    end
    // Mostly aim at valid positions; the rest fall anywhere from 0 to CAP.
    if (kind != PH_NOISE && $urandom_range(0, 9) != 0) begin
      if (op == OP_INSERT) pos = PW'($urandom_range(0, plan_level));
      else if (op == OP_ERASE && plan_level > 0) pos = PW'($urandom_range(0, plan_level - 1));
    end
    add_request(op, val, pos);
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_replies.insert(expected_replies.size(), apply_request(in_flight));
        accepted++;
      end
      if (!req_valid || req_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          req_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          in_flight = pending[0];
          pending.delete(0);
          operation <= in_flight.op;
          value     <= in_flight.value;
          position  <= in_flight.position;
          req_valid <= 1'b1;
          if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
          send_wait = send_calm ? 0 : $urandom_range(0, 18);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor and checker.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t: reply beat with nothing expected: status %0d count %0d",
                   $time, status, count);
        end else begin
          want = expected_replies[0];
          expected_replies.delete(0);
          if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, status);
          end
          if (count !== want.count) begin
            errors++;
            $display("%0t: count expected %0d, got %0d",
                     $time, want.count, count);
          end
          if (front_value !== want.front) begin
            errors++;
            $display("%0t: front_value expected %h, got %h",
                     $time, want.front, front_value);
          end
          if (back_value !== want.back) begin
            errors++;
            $display("%0t: back_value expected %h, got %h",
                     $time, want.back, back_value);
          end
          if (not_empty !== want.not_empty) begin
            errors++;
            $display("%0t: not_empty expected %0d, got %0d",
                     $time, want.not_empty, not_empty);
          end
          checked++;
          status_seen[want.status]++;
          if (int'(want.count) > peak_level) peak_level = int'(want.count);
        end
        if ($urandom_range(0, 59) == 0) take_calm = !take_calm;
        take_wait = take_calm ? 0 : $urandom_range(0, 18);
      end
      if (take_wait > 0) begin
        take_wait--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  initial begin
    phase_kind_t kind;
    int          len;
    // Directed opening: failures on an empty sequence, both ends, inserts and
    // erases at the edges and the middle, and clear on a non-empty and an empty sequence.
    add_request(OP_POP_BACK,   '0,           '0);
    add_request(OP_POP_FRONT,  '1,           '1);
    add_request(OP_ERASE,      '0,           7'd0);
    add_request(OP_ERASE,      '0,           7'd64);
    add_request(OP_INSERT,     32'h1111_1111, 7'd1);
    add_request(OP_INSERT,     32'h2222_2222, 7'd64);
    add_request(OP_INSERT,     32'hFFFF_FFFF, 7'd0);
    add_request(OP_PUSH_BACK,  32'h0000_0000, 7'd0);
    add_request(OP_PUSH_FRONT, 32'h5A5A_5A5A, 7'd0);
    add_request(OP_PUSH_BACK,  32'hFFFF_FFFF, 7'd0);
    add_request(OP_INSERT,     32'h1234_5678, 7'd4);
    add_request(OP_INSERT,     32'h0000_0000, 7'd2);
    add_request(OP_INSERT,     32'hA5A5_A5A5, 7'd7);
    add_request(OP_ERASE,      '0,           7'd6);
    add_request(OP_ERASE,      '0,           7'd0);
    add_request(OP_ERASE,      '0,           7'd4);
    add_request(OP_ERASE,      '0,           7'd1);
    add_request(OP_POP_FRONT,  '0,           7'd0);
    add_request(OP_POP_BACK,   '0,           7'd0);
    add_request(OP_CLEAR,      '0,           7'd0);
    add_request(OP_CLEAR,      '1,           '1);
    add_request(OP_PUSH_FRONT, 32'h0000_0001, 7'd0);
    add_request(OP_POP_BACK,   '0,           7'd0);

    // Random phases that lean towards filling, lean towards draining, hover, or just spray.
    while (planned < 1600) begin
      kind = phase_kind_t'($urandom_range(0, 3));
      len = (kind == PH_FILL || kind == PH_DRAIN) ? $urandom_range(60, 110)
                                                  : $urandom_range(20, 80);
      repeat (len) random_request(kind);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (accepted != planned || expected_replies.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Checked %0d replies from %0d requests; deepest occupancy %0d of %0d.",
             checked, accepted, peak_level, CAP);
    $display("Status mix: ok %0d, full %0d, empty %0d, bad position %0d.",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_BADPOS]);
    if (errors == 0) begin
      $display("positional_deque_tb passed");
    end else begin
      $display("positional_deque_tb failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("positional_deque_tb failed");
    $finish;
  end

endmodule
